// ----- design/fbp_pkg.sv -----
package fbp_pkg;

  localparam int unsigned STACK_DEPTH = 256;
  localparam int unsigned NODE_BYTES  = 4;

  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned FUNC_W  = 2;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned COUNT_W = 9;

  localparam logic [FUNC_W-1:0] FUNC_ALLOC  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_FREE   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_REGION = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd1;
  localparam logic [STAT_W-1:0] ST_REJECT = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL   = 2'd3;

  typedef struct packed {
    logic load;
    logic step;
  } carve_ctrl_t;

  typedef struct packed {
    logic              fit;
    logic [ADDR_W-1:0] addr;
  } carve_stat_t;

endpackage

// ----- design/fbp_if.sv -----
interface fbp_req_if;
  logic                               valid;
  logic                               ready;
  logic [fbp_pkg::FUNC_W-1:0]         func;
  logic [fbp_pkg::ADDR_W-1:0]         addr;
  logic [fbp_pkg::ADDR_W-1:0]         region_size;
  logic [fbp_pkg::ADDR_W-1:0]         chunk_size;

  modport source (output valid, func, addr, region_size, chunk_size, input ready);
  modport sink   (input valid, func, addr, region_size, chunk_size, output ready);
endinterface

interface fbp_rsp_if;
  logic                               valid;
  logic                               ready;
  logic [fbp_pkg::STAT_W-1:0]         status;
  logic [fbp_pkg::ADDR_W-1:0]         block_addr;
  logic [fbp_pkg::COUNT_W-1:0]        free_count;

  modport source (output valid, status, block_addr, free_count, input ready);
  modport sink   (input valid, status, block_addr, free_count, output ready);
endinterface

// ----- design/fbp_stack.sv -----
module fbp_stack #(
  parameter int unsigned DEPTH = fbp_pkg::STACK_DEPTH
) (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [$clog2(DEPTH)-1:0]    waddr_i,
  input  logic [fbp_pkg::ADDR_W-1:0]  wdata_i,
  input  logic [$clog2(DEPTH)-1:0]    raddr_i,
  output logic [fbp_pkg::ADDR_W-1:0]  rdata_o
);

  logic [fbp_pkg::ADDR_W-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- design/fbp_carve.sv -----
module fbp_carve (
  input  logic                        clk_i,
  input  fbp_pkg::carve_ctrl_t        ctrl_i,
  input  logic [fbp_pkg::ADDR_W-1:0]  base_i,
  input  logic [fbp_pkg::ADDR_W-1:0]  region_size_i,
  input  logic [fbp_pkg::ADDR_W-1:0]  chunk_size_i,
  output fbp_pkg::carve_stat_t        stat_o
);

  logic [fbp_pkg::ADDR_W-1:0] rem_q, isz_q, addr_q;

  // remaining bytes and next item address, stepped once per pushed item
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      rem_q  <= region_size_i;
      isz_q  <= chunk_size_i;
      addr_q <= base_i;
    end else if (ctrl_i.step) begin
      rem_q  <= rem_q - isz_q;
      addr_q <= addr_q + isz_q;
    end
  end

  assign stat_o.fit  = rem_q >= isz_q;
  assign stat_o.addr = addr_q;

endmodule

// ----- design/fixed_block_free_list_pool.sv -----
// Free, rejected region, empty allocate and unused func load the result register
// when the item is taken; allocate first reads the registered stack, then loads it.
// Add region: items are pushed one item per cycle through the carve subtract/compare
// unit until no item fits or the stack is full. One item is in work at a time.
// Ready only while idle with the result slot free.
// Reset clears the free count, sequencer and output valid; stack is not cleared.
module fixed_block_free_list_pool #(
  parameter int unsigned STACK_DEPTH = fbp_pkg::STACK_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  fbp_req_if.sink    req_i,
  fbp_rsp_if.source  rsp_o
);

  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AW = $clog2(STACK_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_READ  = 3'b010,
    S_CARVE = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic [CW-1:0] count_q, count_d;

  logic                             accept, empty, full;
  logic                             we;
  logic [fbp_pkg::ADDR_W-1:0]       wdata, rd_data;
  logic [CW-1:0]                    count_dec;
  fbp_pkg::carve_ctrl_t             cctrl;
  fbp_pkg::carve_stat_t             cstat;

  logic                             out_load;
  logic [fbp_pkg::STAT_W-1:0]       st_d;
  logic [fbp_pkg::ADDR_W-1:0]       blk_d;
  logic                             rsp_valid_q;
  logic [fbp_pkg::STAT_W-1:0]       status_q;
  logic [fbp_pkg::ADDR_W-1:0]       block_q;
  logic [fbp_pkg::COUNT_W-1:0]      fcount_q;

  assign empty     = count_q == '0;
  assign full      = count_q == CW'(STACK_DEPTH);
  assign count_dec = count_q - CW'(1);

  assign req_i.ready = (state_q == S_IDLE) && (!rsp_valid_q || rsp_o.ready);
  assign accept      = req_i.valid && req_i.ready;

  fbp_stack #(
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i (wdata),
    .raddr_i (count_dec[AW-1:0]),
    .rdata_o (rd_data)
  );

  fbp_carve u_carve (
    .clk_i         (clk_i),
    .ctrl_i        (cctrl),
    .base_i        (req_i.addr),
    .region_size_i (req_i.region_size),
    .chunk_size_i  (req_i.chunk_size),
    .stat_o        (cstat)
  );

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    we       = 1'b0;
    wdata    = req_i.addr;
    cctrl    = '0;
    out_load = 1'b0;
    st_d     = fbp_pkg::ST_OK;
    blk_d    = '0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (req_i.func)
            fbp_pkg::FUNC_ALLOC: begin
              if (empty) begin
                out_load = 1'b1;
                st_d     = fbp_pkg::ST_EMPTY;
              end else begin
                count_d = count_dec;
                state_d = S_READ;
              end
            end
            fbp_pkg::FUNC_FREE: begin
              out_load = 1'b1;
              if (full) begin
                st_d = fbp_pkg::ST_FULL;
              end else begin
                we      = 1'b1;
                count_d = count_q + CW'(1);
              end
            end
            fbp_pkg::FUNC_REGION: begin
              if (req_i.chunk_size < fbp_pkg::ADDR_W'(fbp_pkg::NODE_BYTES) ||
                  req_i.region_size < req_i.chunk_size) begin
                out_load = 1'b1;
                st_d     = fbp_pkg::ST_REJECT;
              end else begin
                cctrl.load = 1'b1;
                state_d    = S_CARVE;
              end
            end
            default: out_load = 1'b1;
          endcase
        end
      end
      S_READ: begin
        out_load = 1'b1;
        blk_d    = rd_data;
        state_d  = S_IDLE;
      end
      S_CARVE: begin
        if (cstat.fit && !full) begin
          we         = 1'b1;
          wdata      = cstat.addr;
          count_d    = count_q + CW'(1);
          cctrl.step = 1'b1;
        end else begin
          out_load = 1'b1;
          st_d     = cstat.fit ? fbp_pkg::ST_FULL : fbp_pkg::ST_OK;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (out_load) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      status_q <= st_d;
      block_q  <= blk_d;
      fcount_q <= fbp_pkg::COUNT_W'(count_d);
    end
  end

  assign rsp_o.valid      = rsp_valid_q;
  assign rsp_o.status     = status_q;
  assign rsp_o.block_addr = block_q;
  assign rsp_o.free_count = fcount_q;

  // result slot is always empty while an item is in work
  a_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !rsp_valid_q)
    else $error("result pending during multi-cycle item");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(STACK_DEPTH))
    else $error("free count beyond stack depth");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> (!full && count_d == count_q + CW'(1)))
    else $error("push without room or count step");

  a_alloc_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ) |=> (rsp_valid_q && state_q == S_IDLE))
    else $error("allocate did not complete");

endmodule
